// ===== rtl/core/haversine_great_circle_distance_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the haversine distance core
// Shared concurrent-assertion forms; the including module supplies
// i_clk and i_rst_n.
// ---------------------------------------------------------------------------
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_MACROS_SVH

// same-cycle implication
`define HGCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HGCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hgcd_pkg.sv =====
// ---------------------------------------------------------------------------
// hgcd_pkg
// Widths, constants, job type and arctangent table for the distance core.
// ---------------------------------------------------------------------------
package hgcd_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 31;
    localparam int STEP_MAX      = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int CNT_W         = $clog2(STEP_MAX);

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int DIST_W = 31;
    localparam int ANG_W  = 34;   // angle in half-units, before reduction
    localparam int RED_W  = 35;   // reduction work width
    localparam int MAG_W  = 31;   // folded magnitude
    localparam int CW     = 36;   // CORDIC datapath
    localparam int QW     = 33;   // Q2.30 trig values and products
    localparam int MW     = 34;   // multiplier operand
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic signed [RED_W-1:0] HU_FULL    = 35'sd7200000000;
    localparam logic signed [RED_W-1:0] HU_HALF    = 35'sd3600000000;
    localparam logic signed [RED_W-1:0] HU_QUARTER = 35'sd1800000000;

    // round(pi * 2^31) = 2^32 + PI_LO
    localparam logic [31:0] PI_LO    = 32'd2451551556;
    localparam logic [33:0] DIV_D    = 34'd7200000000;
    localparam logic [34:0] DIV_D2   = 35'd14400000000;
    localparam logic [63:0] DIV_BIAS = 64'd3600000000;
    // floor(round(pi * 2^31) * 2^32 / 7.2e9): quotient estimate, low by at most 2
    localparam logic [31:0] REC_M    = 32'((96'd6746518852 << 32) / 96'd7200000000);

    localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic [30:0]          Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0]          RADIUS2_CM  = 31'd1274200000;
    localparam logic [30:0]          DIST_MAX    = 31'd2001508680;

    localparam logic signed [LAT_W-1:0] DEST_LAT_RST = 31'sd472750634;
    localparam logic signed [LON_W-1:0] DEST_LON_RST = -32'sd15062181;

    // register index, decoded from paddr[2]
    localparam logic REG_DEST_LAT = 1'b0;
    localparam logic REG_DEST_LON = 1'b1;

    // angle slots of a job
    localparam logic [1:0] ANG_DLAT = 2'd0;
    localparam logic [1:0] ANG_DLON = 2'd1;
    localparam logic [1:0] ANG_LAT1 = 2'd2;
    localparam logic [1:0] ANG_LAT2 = 2'd3;

    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [ANG_W-1:0] t_ang;
    typedef t_ang [3:0] t_job;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [CW-1:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic signed [CW-1:0] t;
        int k;
        k = int'(idx);
        case (k)
            0: t = CW'(843314856);
            1: t = CW'(497837829);
            2: t = CW'(263043836);
            3: t = CW'(133525158);
            4: t = CW'(67021686);
            5: t = CW'(33543515);
            6: t = CW'(16775850);
            7: t = CW'(8388437);
            8: t = CW'(4194282);
            9: t = CW'(2097149);
            default: t = (k <= 30) ? ((CW'(1) << (30 - k)) - CW'(1)) : '0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/haversine_great_circle_distance.sv =====
// ---------------------------------------------------------------------------
// haversine_great_circle_distance
// Great-circle distance in centimetres from an origin (1e-7 degree units) to
// a destination held in two APB registers (dest_lat at 0x0, dest_lon at 0x4,
// decoded on paddr[2]), by the haversine formula on a 6371 km sphere, in
// Q2.30 fixed point with CORDIC sine, cosine and atan2. Results saturate at
// 2001508680 cm. One result per origin, in order. Each item passes through
// the back-end sequencer in turn: four angle reductions, each with a
// reciprocal-multiply scaling to radians and a CORDIC rotation, then four
// shared multiplies, two 31-step square roots, a CORDIC vectoring pass and
// the final scaling. The single iterative sequencer takes no new item until
// it has finished the last. Up to three further origins are buffered ahead
// of it (input register plus a two-entry queue), and a finished distance
// waits in an output register while the next item is already under way.
// Write the destination only while no item is in flight.
// ---------------------------------------------------------------------------
module haversine_great_circle_distance (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hgcd_pkg::APB_AW-1:0]        paddr,
    input  logic [hgcd_pkg::APB_DW-1:0]        pwdata,
    output logic [hgcd_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // origin transfer
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [hgcd_pkg::LAT_W-1:0]  i_origin_lat,
    input  logic signed [hgcd_pkg::LON_W-1:0]  i_origin_lon,
    // distance transfer
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [hgcd_pkg::DIST_W-1:0]        o_distance_cm
);

    logic signed [hgcd_pkg::LAT_W-1:0] r_dest_lat;
    logic signed [hgcd_pkg::LON_W-1:0] r_dest_lon;
    logic                              cfg_wr;
    logic                              reg_sel;

    logic           fr_valid, fr_ready;
    hgcd_pkg::t_job fr_job;
    logic           q_valid, q_ready;
    hgcd_pkg::t_job q_job;

    // register index is the word address; low address bits are ignored
    assign reg_sel = paddr[hgcd_pkg::APB_AW-1];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == hgcd_pkg::REG_DEST_LON) ? r_dest_lon :
                     hgcd_pkg::APB_DW'(r_dest_lat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_lat <= hgcd_pkg::DEST_LAT_RST;
            r_dest_lon <= hgcd_pkg::DEST_LON_RST;
        end else if (cfg_wr) begin
            if (reg_sel == hgcd_pkg::REG_DEST_LAT) begin
                r_dest_lat <= pwdata[hgcd_pkg::LAT_W-1:0];
            end else begin
                r_dest_lon <= pwdata[hgcd_pkg::LON_W-1:0];
            end
        end
    end

    // front end: takes the transfer, forms the four half-unit angles
    hgcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_origin_lat (i_origin_lat),
        .i_origin_lon (i_origin_lon),
        .i_dest_lat   (r_dest_lat),
        .i_dest_lon   (r_dest_lon),
        .o_valid      (fr_valid),
        .i_ready      (fr_ready),
        .o_job        (fr_job)
    );

    // job queue decouples front and back end stalls
    hgcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_job   (fr_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    // back end: iterative trig / root / atan2 sequencer with output register
    hgcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_job         (q_job),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_distance_cm (o_distance_cm)
    );

endmodule

// ===== rtl/core/hgcd_front.sv =====
// ---------------------------------------------------------------------------
// hgcd_front
// Input register: takes an origin and forms the four angles of the job.
// ---------------------------------------------------------------------------
module hgcd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [hgcd_pkg::LAT_W-1:0] i_origin_lat,
    input  logic signed [hgcd_pkg::LON_W-1:0] i_origin_lon,
    input  logic signed [hgcd_pkg::LAT_W-1:0] i_dest_lat,
    input  logic signed [hgcd_pkg::LON_W-1:0] i_dest_lon,
    output logic                              o_valid,
    input  logic                              i_ready,
    output hgcd_pkg::t_job                    o_job
);

    logic           r_valid;
    hgcd_pkg::t_job r_job;
    hgcd_pkg::t_job n_job;

    always_comb begin
        n_job[hgcd_pkg::ANG_DLAT] = hgcd_pkg::ANG_W'(i_dest_lat) - hgcd_pkg::ANG_W'(i_origin_lat);
        n_job[hgcd_pkg::ANG_DLON] = hgcd_pkg::ANG_W'(i_dest_lon) - hgcd_pkg::ANG_W'(i_origin_lon);
        n_job[hgcd_pkg::ANG_LAT1] = hgcd_pkg::ANG_W'(i_origin_lat) + hgcd_pkg::ANG_W'(i_origin_lat);
        n_job[hgcd_pkg::ANG_LAT2] = hgcd_pkg::ANG_W'(i_dest_lat) + hgcd_pkg::ANG_W'(i_dest_lat);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/core/hgcd_fifo.sv =====
// ---------------------------------------------------------------------------
// hgcd_fifo
// Short job queue between front and back end.
// ---------------------------------------------------------------------------
module hgcd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hgcd_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output hgcd_pkg::t_job o_job
);

    hgcd_pkg::t_job                r_mem [hgcd_pkg::FIFO_DEPTH];
    logic [hgcd_pkg::FPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [hgcd_pkg::FPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [hgcd_pkg::FCNT_W-1:0]   r_count, n_count;
    logic                          push, pop;

    localparam logic [hgcd_pkg::FPTR_W-1:0] PTR_LAST = hgcd_pkg::FPTR_W'(hgcd_pkg::FIFO_DEPTH - 1);
    localparam logic [hgcd_pkg::FCNT_W-1:0] CNT_FULL = hgcd_pkg::FCNT_W'(hgcd_pkg::FIFO_DEPTH);

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/hgcd_back.sv =====
// ---------------------------------------------------------------------------
// hgcd_back
// Sequencer: angle reduction, CORDIC sin/cos, haversine term, square roots,
// CORDIC atan2 and scaling to centimetres. One shared CORDIC step, a
// reciprocal-multiply angle scaling, two square-root steps and one multiplier.
// ---------------------------------------------------------------------------
`include "haversine_great_circle_distance_macros.svh"

module hgcd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  hgcd_pkg::t_job                     i_job,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [hgcd_pkg::DIST_W-1:0]        o_distance_cm
);

    localparam int CW    = hgcd_pkg::CW;
    localparam int QW    = hgcd_pkg::QW;
    localparam int MW    = hgcd_pkg::MW;
    localparam int RED_W = hgcd_pkg::RED_W;
    localparam int CNT_W = hgcd_pkg::CNT_W;

    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(hgcd_pkg::SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(hgcd_pkg::CORDIC_STAGES - 1);
    localparam logic signed [CW-1:0] X_ONE   = CW'(1) << 30;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_WRAP = 20'h00002,
        S_FOLD = 20'h00004,
        S_MUL  = 20'h00008,
        S_DIV0 = 20'h00010,
        S_DIV  = 20'h00020,
        S_ZSET = 20'h00040,
        S_ROT  = 20'h00080,
        S_SAVE = 20'h00100,
        S_M1   = 20'h00200,
        S_M2   = 20'h00400,
        S_M3   = 20'h00800,
        S_M4   = 20'h01000,
        S_M5   = 20'h02000,
        S_M6   = 20'h04000,
        S_SQ0  = 20'h08000,
        S_SQRT = 20'h10000,
        S_VEC  = 20'h20000,
        S_DMUL = 20'h40000,
        S_FIN  = 20'h80000
    } t_state;

    typedef struct packed {
        logic [60:0] n;
        logic [61:0] res;
    } t_sq;

    function automatic t_sq sq_step(input t_sq cur, input logic [61:0] bitv);
        t_sq         nx;
        logic [61:0] sum;
        sum = cur.res + bitv;
        if ({1'b0, cur.n} >= sum) begin
            nx.n   = cur.n - sum[60:0];
            nx.res = (cur.res >> 1) + bitv;
        end else begin
            nx.n   = cur.n;
            nx.res = cur.res >> 1;
        end
        return nx;
    endfunction

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [1:0]              r_ang, n_ang;
    hgcd_pkg::t_job          r_job, n_job;
    logic signed [RED_W-1:0] r_r, n_r;
    logic                    r_flip, n_flip;
    logic                    r_neg, n_neg;
    logic [hgcd_pkg::MAG_W-1:0] r_mag, n_mag;
    logic signed [63:0]      r_prod;
    logic [63:0]             r_num, n_num;
    logic [30:0]             r_dlow, n_dlow;
    logic signed [CW-1:0]    r_x, n_x, r_y, n_y, r_z, n_z;
    logic signed [QW-1:0]    r_sl, n_sl, r_s2, n_s2, r_c1, n_c1, r_c2, n_c2;
    logic signed [QW-1:0]    r_sl2, n_sl2, r_s22, n_s22, r_cc, n_cc;
    logic signed [34:0]      r_a, n_a;
    t_sq                     r_sa, n_sa, r_sb, n_sb;
    logic                    r_out_valid, n_out_valid;
    logic [hgcd_pkg::DIST_W-1:0] r_out_dist, n_out_dist;

    // shared datapath signals
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [2*MW-1:0]  mul_p;
    logic                    mul_en;
    logic signed [63:0]      prod_rnd;
    logic signed [QW-1:0]    rnd_q;
    logic signed [RED_W-1:0] ang_v, fold_v;
    logic [63:0]             div_n;
    logic [63:0]             div_rem;
    logic [30:0]             q_fix;
    logic signed [CW-1:0]    c_dx, c_dy, c_at;
    logic                    c_s;
    logic [5:0]              sq_sh;
    logic [61:0]             sq_bit;
    t_sq                     sa_nx, sb_nx;
    logic [30:0]             a_clamp;
    logic [30:0]             z_clamp;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_distance_cm = r_out_dist;

    assign mul_p    = mul_a * mul_b;
    assign prod_rnd = (r_prod + 64'sd536870912) >>> 30;
    assign rnd_q    = QW'(prod_rnd);

    assign ang_v  = RED_W'($signed(r_job[r_ang]));
    assign div_n  = {1'b0, r_mag, 32'd0} + $unsigned(r_prod) + hgcd_pkg::DIV_BIAS;
    // quotient estimate is low by 0, 1 or 2; the remainder picks the step
    assign div_rem = r_num - $unsigned(r_prod);
    assign q_fix   = r_dlow + ((div_rem >= 64'(hgcd_pkg::DIV_D2)) ? 31'd2 :
                               (div_rem >= 64'(hgcd_pkg::DIV_D))  ? 31'd1 : 31'd0);

    // CORDIC step: rotation drives z to zero, vectoring drives y to zero
    assign c_dx = r_y >>> r_cnt;
    assign c_dy = r_x >>> r_cnt;
    assign c_at = hgcd_pkg::atan_q30(r_cnt);
    assign c_s  = (r_state == S_ROT) ? (r_z < 0) : (r_y >= 0);

    assign sq_sh  = 6'(60 - 2 * int'(r_cnt));
    assign sq_bit = 62'(1) << sq_sh;
    assign sa_nx  = sq_step(r_sa, sq_bit);
    assign sb_nx  = sq_step(r_sb, sq_bit);

    assign a_clamp = (r_a < 0) ? '0 :
                     (r_a > $signed({4'd0, hgcd_pkg::Q30_ONE})) ? hgcd_pkg::Q30_ONE : r_a[30:0];
    assign z_clamp = (r_z < 0) ? '0 : r_z[30:0];

    // multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (r_state)
            S_MUL: begin
                mul_a  = $signed(MW'(r_mag));
                mul_b  = $signed(MW'(hgcd_pkg::PI_LO));
                mul_en = 1'b1;
            end
            S_DIV0: begin
                mul_a  = $signed(MW'(r_mag));
                mul_b  = $signed(MW'(hgcd_pkg::REC_M));
                mul_en = 1'b1;
            end
            S_DIV: begin
                mul_a  = $signed(MW'(r_prod[62:32]));
                mul_b  = $signed(MW'(hgcd_pkg::DIV_D));
                mul_en = 1'b1;
            end
            S_M1: begin
                mul_a  = MW'(r_sl);
                mul_b  = MW'(r_sl);
                mul_en = 1'b1;
            end
            S_M2: begin
                mul_a  = MW'(r_s2);
                mul_b  = MW'(r_s2);
                mul_en = 1'b1;
            end
            S_M3: begin
                mul_a  = MW'(r_c1);
                mul_b  = MW'(r_c2);
                mul_en = 1'b1;
            end
            S_M5: begin
                mul_a  = MW'(r_cc);
                mul_b  = MW'(r_s22);
                mul_en = 1'b1;
            end
            S_DMUL: begin
                mul_a  = $signed(MW'(z_clamp));
                mul_b  = $signed(MW'(hgcd_pkg::RADIUS2_CM));
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // half-turn fold into [-90, +90] degrees
    always_comb begin
        if (r_r > hgcd_pkg::HU_QUARTER) begin
            fold_v = r_r - hgcd_pkg::HU_HALF;
        end else if (r_r < -hgcd_pkg::HU_QUARTER) begin
            fold_v = r_r + hgcd_pkg::HU_HALF;
        end else begin
            fold_v = r_r;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ang       = r_ang;
        n_job       = r_job;
        n_r         = r_r;
        n_flip      = r_flip;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_num       = r_num;
        n_dlow      = r_dlow;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_sl        = r_sl;
        n_s2        = r_s2;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_sl2       = r_sl2;
        n_s22       = r_s22;
        n_cc        = r_cc;
        n_a         = r_a;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_out_valid = r_out_valid && !i_ready;
        n_out_dist  = r_out_dist;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_job   = i_job;
                    n_ang   = hgcd_pkg::ANG_DLAT;
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (ang_v >= hgcd_pkg::HU_HALF) begin
                    n_r = ang_v - hgcd_pkg::HU_FULL;
                end else if (ang_v < -hgcd_pkg::HU_HALF) begin
                    n_r = ang_v + hgcd_pkg::HU_FULL;
                end else begin
                    n_r = ang_v;
                end
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_flip  = (r_r > hgcd_pkg::HU_QUARTER) || (r_r < -hgcd_pkg::HU_QUARTER);
                n_neg   = fold_v < 0;
                n_mag   = hgcd_pkg::MAG_W'((fold_v < 0) ? -fold_v : fold_v);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV0;
            end
            S_DIV0: begin
                // numerator mag * round(pi * 2^31) + 3.6e9
                n_num   = div_n;
                n_state = S_DIV;
            end
            S_DIV: begin
                // quotient estimate from the reciprocal product
                n_dlow  = r_prod[62:32];
                n_state = S_ZSET;
            end
            S_ZSET: begin
                n_x     = hgcd_pkg::CORDIC_GAIN;
                n_y     = '0;
                n_z     = r_neg ? -$signed(CW'(q_fix)) : $signed(CW'(q_fix));
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                n_x = c_s ? r_x + c_dx : r_x - c_dx;
                n_y = c_s ? r_y - c_dy : r_y + c_dy;
                n_z = c_s ? r_z + c_at : r_z - c_at;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = S_SAVE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SAVE: begin
                case (r_ang)
                    hgcd_pkg::ANG_DLAT: n_sl = QW'(r_flip ? -r_y : r_y);
                    hgcd_pkg::ANG_DLON: n_s2 = QW'(r_flip ? -r_y : r_y);
                    hgcd_pkg::ANG_LAT1: n_c1 = QW'(r_flip ? -r_x : r_x);
                    hgcd_pkg::ANG_LAT2: n_c2 = QW'(r_flip ? -r_x : r_x);
                    default:            n_sl = r_sl;
                endcase
                if (r_ang == hgcd_pkg::ANG_LAT2) begin
                    n_state = S_M1;
                end else begin
                    n_ang   = r_ang + 1'b1;
                    n_state = S_WRAP;
                end
            end
            S_M1: begin
                n_state = S_M2;
            end
            S_M2: begin
                n_sl2   = rnd_q;
                n_state = S_M3;
            end
            S_M3: begin
                n_s22   = rnd_q;
                n_state = S_M4;
            end
            S_M4: begin
                n_cc    = rnd_q;
                n_state = S_M5;
            end
            S_M5: begin
                n_state = S_M6;
            end
            S_M6: begin
                n_a     = 35'(r_sl2) + 35'(rnd_q);
                n_state = S_SQ0;
            end
            S_SQ0: begin
                n_sa.n   = {a_clamp, 30'd0};
                n_sa.res = '0;
                n_sb.n   = {hgcd_pkg::Q30_ONE - a_clamp, 30'd0};
                n_sb.res = '0;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                n_sa = sa_nx;
                n_sb = sb_nx;
                if (r_cnt == SQRT_LAST) begin
                    n_x     = CW'(sb_nx.res);
                    n_y     = CW'(sa_nx.res);
                    n_z     = '0;
                    n_cnt   = '0;
                    n_state = S_VEC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_VEC: begin
                n_x = c_s ? r_x + c_dx : r_x - c_dx;
                n_y = c_s ? r_y - c_dy : r_y + c_dy;
                n_z = c_s ? r_z + c_at : r_z - c_at;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = S_DMUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DMUL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // wait here while the previous result is still held
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = (prod_rnd > $signed({33'd0, hgcd_pkg::DIST_MAX})) ?
                                  hgcd_pkg::DIST_MAX : prod_rnd[30:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ang       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_ang       <= n_ang;
        end
        r_job      <= n_job;
        r_r        <= n_r;
        r_flip     <= n_flip;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_num      <= n_num;
        r_dlow     <= n_dlow;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_sl       <= n_sl;
        r_s2       <= n_s2;
        r_c1       <= n_c1;
        r_c2       <= n_c2;
        r_sl2      <= n_sl2;
        r_s22      <= n_s22;
        r_cc       <= n_cc;
        r_a        <= n_a;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_out_dist <= n_out_dist;
        if (mul_en) begin
            r_prod <= mul_p[63:0];
        end
    end

    `HGCD_ASSERT_NOW(a_dist_range, r_out_valid, r_out_dist <= hgcd_pkg::DIST_MAX, "distance above half circumference")
    `HGCD_ASSERT_NEXT(a_fin_hold, (r_state == S_FIN) && r_out_valid && !i_ready, r_state == S_FIN, "result overwritten while held")
    `HGCD_ASSERT_NOW(a_mag_range, r_state == S_MUL, r_mag <= 31'd1800000000, "folded angle beyond quarter turn")
    `HGCD_ASSERT_NOW(a_sqrt_range, (r_state == S_VEC) && (r_cnt == '0), (r_x >= 0) && (r_x <= X_ONE) && (r_y >= 0) && (r_y <= X_ONE), "square root out of unit range")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Haversine distance core testbench
// Sends origin positions through the valid/ready port, writes the destination
// over APB between phases, and checks each distance against a fixed-point
// predictor of the haversine formula computed here.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LAT_W  = hgcd_pkg::LAT_W;
    localparam int LON_W  = hgcd_pkg::LON_W;
    localparam int DIST_W = hgcd_pkg::DIST_W;
    localparam int APB_AW = hgcd_pkg::APB_AW;
    localparam int APB_DW = hgcd_pkg::APB_DW;

    // half-unit angle constants (0.5e-7 degree) and Q2.30 scale factors
    localparam longint TURN_HU    = 64'sd7200000000;
    localparam longint HALF_HU    = 64'sd3600000000;
    localparam longint QUARTER_HU = 64'sd1800000000;
    localparam longint unsigned PI_SCALED = 64'd6746518852;
    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint RADIUS_CM  = 64'sd637100000;
    localparam longint SAT_CM     = 64'sd2001508680;
    localparam int     N_STAGES   = 24;

    localparam logic [APB_AW-1:0] ADDR_DEST_LAT = 3'h0;
    localparam logic [APB_AW-1:0] ADDR_DEST_LON = 3'h4;

    // idle patterns per phase
    localparam int MODE_SRC_IDLE = 0;   // sender 37%, receiver 58%
    localparam int MODE_DST_IDLE = 1;   // swapped
    localparam int MODE_NO_IDLE  = 2;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 400;

    typedef struct {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_origin;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [LAT_W-1:0]  i_origin_lat = '0;
    logic signed [LON_W-1:0]  i_origin_lon = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [DIST_W-1:0]        o_distance_cm;

    t_origin           origins_pending[$];
    logic [DIST_W-1:0] distances_due[$];

    // destination as the core should currently hold it
    longint dest_lat_q = 472750634;
    longint dest_lon_q = -15062181;

    int idle_mode = MODE_SRC_IDLE;
    int mismatches = 0;
    int stall_count = 0;

    always #1 i_clk = ~i_clk;

    haversine_great_circle_distance u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_origin_lat  (i_origin_lat),
        .i_origin_lon  (i_origin_lon),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_distance_cm (o_distance_cm)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // floor(atan(2^-i) * 2^30)
    function automatic longint rot_angle(input int i);
        case (i)
            0: return 843314856;
            1: return 497837829;
            2: return 263043836;
            3: return 133525158;
            4: return 67021686;
            5: return 33543515;
            6: return 16775850;
            7: return 8388437;
            8: return 4194282;
            9: return 2097149;
            default: return (i <= 30) ? ((64'sd1 << (30 - i)) - 1) : 0;
        endcase
    endfunction

    // Q2.30 product, ties rounded toward +inf
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // angle in half-units -> Q2.30 sine and cosine
    task automatic trig_of(input longint ang, output longint sn, output longint cs);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit flip;
        bit neg;
        longint unsigned mag;
        r = ang % TURN_HU;
        flip = 1'b0;
        if (r >= HALF_HU)
            r -= TURN_HU;
        else if (r < -HALF_HU)
            r += TURN_HU;
        // fold into +-90 degrees; both sine and cosine change sign
        if (r > QUARTER_HU) begin
            r -= HALF_HU;
            flip = 1'b1;
        end else if (r < -QUARTER_HU) begin
            r += HALF_HU;
            flip = 1'b1;
        end
        neg = r < 0;
        mag = neg ? longint'(-r) : longint'(r);
        z = longint'((mag * PI_SCALED + longint'(HALF_HU)) / longint'(TURN_HU));
        if (neg)
            z = -z;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= rot_angle(i);
            end else begin
                x += dx; y -= dy; z += rot_angle(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // vectoring CORDIC: angle of (x, y) in Q2.30 radians
    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += rot_angle(i);
            end else begin
                x -= dx; y += dy; z -= rot_angle(i);
            end
        end
        return z;
    endfunction

    task automatic predict_distance(input t_origin o, output logic [DIST_W-1:0] d);
        longint lat1;
        longint lon1;
        longint s_dlat;
        longint s_dlon;
        longint s_lat1;
        longint c_lat1;
        longint s_lat2;
        longint c_lat2;
        longint unused;
        longint hav;
        longint z;
        longint dist_cm;
        lat1 = o.lat;
        lon1 = o.lon;
        // differences in 1e-7 degree are already half-angles in half-units
        trig_of(dest_lat_q - lat1, s_dlat, unused);
        trig_of(dest_lon_q - lon1, s_dlon, unused);
        trig_of(lat1 * 2, s_lat1, c_lat1);
        trig_of(dest_lat_q * 2, s_lat2, c_lat2);
        hav = qmul(s_dlat, s_dlat) + qmul(qmul(c_lat1, c_lat2), qmul(s_dlon, s_dlon));
        if (hav < 0)
            hav = 0;
        if (hav > ONE_Q30)
            hav = ONE_Q30;
        z = vector_angle(floor_sqrt(longint'(hav) << 30),
                         floor_sqrt(longint'(ONE_Q30 - hav) << 30));
        if (z < 0)
            z = 0;  // tiny negative residue
        dist_cm = (2 * z * RADIUS_CM + (64'sd1 << 29)) >>> 30;
        if (dist_cm > SAT_CM)
            dist_cm = SAT_CM;
        d = dist_cm[DIST_W-1:0];
    endtask

    // ------------------------------------------------------------------------
    // Driver: origin transfers, fed from origins_pending
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] due;
        bit send;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                predict_distance('{lat: i_origin_lat, lon: i_origin_lon}, due);
                distances_due.push_back(due);
            end
            send = origins_pending.size() != 0;
            if (idle_mode == MODE_SRC_IDLE && $urandom_range(99) < 37)
                send = 1'b0;
            if (idle_mode == MODE_DST_IDLE && $urandom_range(99) < 58)
                send = 1'b0;
            if (send) begin
                t_origin nxt;
                nxt = origins_pending.pop_front();
                i_origin_lat <= nxt.lat;
                i_origin_lon <= nxt.lon;
            end
            i_in_valid <= send;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        case (idle_mode)
            MODE_SRC_IDLE: i_out_ready <= $urandom_range(99) >= 58;
            MODE_DST_IDLE: i_out_ready <= $urandom_range(99) >= 37;
            default:       i_out_ready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: distance transfers against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (distances_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance %0d", o_distance_cm);
            end else begin
                want = distances_due.pop_front();
                if (o_distance_cm !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance_cm mismatch: expected %0d, got %0d",
                                 want, o_distance_cm);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_destination(input longint lat, input longint lon);
        logic signed [LAT_W-1:0] lat_f;
        logic signed [LON_W-1:0] lon_f;
        lat_f = lat[LAT_W-1:0];
        lon_f = lon[LON_W-1:0];
        apb_write(ADDR_DEST_LAT, APB_DW'(lat_f));
        apb_write(ADDR_DEST_LON, APB_DW'(lon_f));
        dest_lat_q = lat_f;
        dest_lon_q = lon_f;
    endtask

    task automatic add_origin(input longint lat, input longint lon);
        origins_pending.push_back('{lat: lat[LAT_W-1:0], lon: lon[LON_W-1:0]});
    endtask

    // wait until every transfer of the phase is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (origins_pending.size() != 0 || i_in_valid || distances_due.size() != 0);
    endtask

    task automatic add_random_origins(input int n);
        longint lat;
        longint lon;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // legal coordinates anywhere on the globe
                lat = longint'($urandom_range(1800000000)) - 900000000;
                lon = longint'($urandom_range(32'd3600000000)) - 1800000000;
            end else if (pick < 75) begin
                // near the destination: short distances
                lat = dest_lat_q + longint'($urandom_range(2000000)) - 1000000;
                lon = dest_lon_q + longint'($urandom_range(2000000)) - 1000000;
            end else begin
                // any bit pattern the ports carry
                lat = longint'(signed'(LAT_W'($urandom())));
                lon = longint'(signed'(LON_W'($urandom())));
            end
            add_origin(lat, lon);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset destination first, directed corners
        idle_mode = MODE_SRC_IDLE;
        add_origin(0, 0);
        add_origin(472750634, -15062181);               // at the destination
        add_origin(-472750634, 1800000000 - 15062181);  // antipode: saturates
        add_origin(900000000, 0);
        add_origin(-900000000, 0);
        add_origin(0, 1800000000);
        add_origin(0, -1800000000);
        add_origin(1073741823, 2147483647);              // beyond the poles
        add_origin(-1073741824, -64'sd2147483648);
        add_origin(1000000000, -1000000000);
        add_origin(472750634, 1784937819);               // longitude wrap
        add_origin(472750000, -15062000);
        add_origin(-1, -1);
        add_origin(1, 1);
        add_random_origins(60);
        wait_drained();

        set_destination(900000000, 1800000000);
        add_origin(-900000000, -1800000000);
        add_origin(900000000, -1800000000);
        add_random_origins(80);
        wait_drained();

        idle_mode = MODE_DST_IDLE;
        set_destination(-900000000, -1800000000);
        add_random_origins(85);
        wait_drained();

        set_destination(0, 0);
        add_origin(0, 1800000000);
        add_random_origins(85);
        wait_drained();

        idle_mode = MODE_NO_IDLE;
        set_destination(1073741823, -64'sd2147483648);
        add_random_origins(85);
        wait_drained();

        set_destination(longint'($urandom_range(1800000000)) - 900000000,
                        longint'($urandom_range(32'd3600000000)) - 1800000000);
        add_random_origins(85);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && distances_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
